FILE: sv/tle_pkg.sv
// ---------------------------------------------------------------------------
// tle_pkg
// Shared types and constants for the terminal line editor.
// ---------------------------------------------------------------------------
package tle_pkg;

  localparam int DATA_W    = 8;
  localparam int LIMIT_W   = 7;
  localparam int CFG_IDX_W = 2;

  // Character codes
  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_BS    = 8'h08;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CTRL_TOP = 8'h1F;

  // Result kinds
  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_LINE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT  = 2'd1;

  localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd2;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  typedef enum logic [1:0] {
    CLS_OTHER,
    CLS_CR,
    CLS_BS,
    CLS_PRINT
  } cls_t;

  // Classified character handed from front to back
  typedef struct packed {
    cls_t              cls;
    logic [DATA_W-1:0] chr;
  } cmd_t;

  // One result item
  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] data;
    logic              last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BS_SP,
    S_BS_END,
    S_PRIME,
    S_EMIT
  } back_state_t;

endpackage

FILE: sv/tle_ram.sv
// ---------------------------------------------------------------------------
// tle_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, read port returns old data on collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tle_front.sv
// ---------------------------------------------------------------------------
// tle_front
// Accepts received characters, drops them while the channel is off and
// classifies the rest for the back end.
// ---------------------------------------------------------------------------
module tle_front (
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [tle_pkg::DATA_W-1:0] in_tdata,
  input  logic                     enable,
  input  logic                     q_ready,
  output logic                     q_push,
  output tle_pkg::cmd_t            q_cmd
);

  tle_pkg::cls_t cls;

  // Classify the character
  always_comb begin
    if (in_tdata == tle_pkg::CH_CR) begin
      cls = tle_pkg::CLS_CR;
    end else if (in_tdata == tle_pkg::CH_BS) begin
      cls = tle_pkg::CLS_BS;
    end else if (in_tdata > tle_pkg::CTRL_TOP) begin
      cls = tle_pkg::CLS_PRINT;
    end else begin
      cls = tle_pkg::CLS_OTHER;
    end
  end

  // Push only while the channel is enabled
  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready && enable;
  assign q_cmd.cls = cls;
  assign q_cmd.chr = in_tdata;

endmodule

FILE: sv/tle_queue.sv
// ---------------------------------------------------------------------------
// tle_queue
// Two-entry queue of classified characters between front and back.
// ---------------------------------------------------------------------------
module tle_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  tle_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          valid,
  output tle_pkg::cmd_t pop_cmd
);

  tle_pkg::cmd_t ent_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r,  count_nxt;

  assign ready   = (count_r != 2'd2);
  assign valid   = (count_r != 2'd0);
  assign pop_cmd = ent_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: sv/tle_back.sv
// ---------------------------------------------------------------------------
// tle_back
// Executes classified characters: echo, backspace sequence, line store
// update and line emission from the store, into one output register.
// ---------------------------------------------------------------------------
module tle_back #(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_valid,
  input  tle_pkg::cmd_t               cmd,
  output logic                        cmd_pop,
  input  logic [tle_pkg::LIMIT_W-1:0] line_limit,
  output logic                        res_valid,
  input  logic                        res_ready,
  output tle_pkg::res_t               res
);

  localparam int AW    = $clog2(LINE_STORE_DEPTH);
  localparam int LEN_W = $clog2(LINE_STORE_DEPTH + 1);
  localparam logic [tle_pkg::LIMIT_W-1:0] DEPTH_LIM = tle_pkg::LIMIT_W'(LINE_STORE_DEPTH);

  tle_pkg::back_state_t state_r, state_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  tle_pkg::res_t        out_r;

  logic                          out_free;
  logic [tle_pkg::LIMIT_W-1:0]   lim, cap, len_ext, len_inc;
  logic                          full, ends_on_add, emit_last;
  logic                          load;
  tle_pkg::res_t                 load_res;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [tle_pkg::DATA_W-1:0]    ram_wdata;
  logic [tle_pkg::DATA_W-1:0]    ram_rdata;

  // Saturate the limit and derive the line capacity
  always_comb begin
    if (line_limit < tle_pkg::LIMIT_MIN) begin
      lim = tle_pkg::LIMIT_MIN;
    end else if (line_limit > DEPTH_LIM) begin
      lim = DEPTH_LIM;
    end else begin
      lim = line_limit;
    end
    cap         = lim - 7'd1;
    len_ext     = tle_pkg::LIMIT_W'(len_r);
    len_inc     = len_ext + 7'd1;
    full        = (len_ext >= cap);
    ends_on_add = (len_inc >= cap);
    emit_last   = (LEN_W'(idx_r) == len_r - LEN_W'(1));
  end

  assign out_free = !out_valid_r || res_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tle_pkg::S_IDLE: begin
        if (cmd_valid && out_free) begin
          if (full) begin
            state_nxt = tle_pkg::S_PRIME;
          end else begin
            case (cmd.cls)
              tle_pkg::CLS_CR:    state_nxt = tle_pkg::S_PRIME;
              tle_pkg::CLS_BS:    state_nxt = (len_r != '0) ? tle_pkg::S_BS_SP : tle_pkg::S_IDLE;
              tle_pkg::CLS_PRINT: state_nxt = ends_on_add ? tle_pkg::S_PRIME : tle_pkg::S_IDLE;
              default:            state_nxt = tle_pkg::S_IDLE;
            endcase
          end
        end
      end
      tle_pkg::S_BS_SP: begin
        if (out_free) state_nxt = tle_pkg::S_BS_END;
      end
      tle_pkg::S_BS_END: begin
        if (out_free) state_nxt = tle_pkg::S_IDLE;
      end
      tle_pkg::S_PRIME: begin
        state_nxt = tle_pkg::S_EMIT;
      end
      tle_pkg::S_EMIT: begin
        if (out_free && emit_last) state_nxt = tle_pkg::S_IDLE;
      end
      default: state_nxt = tle_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    cmd_pop   = 1'b0;
    load      = 1'b0;
    load_res  = '0;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    ram_we    = 1'b0;
    ram_waddr = len_r[AW-1:0];
    ram_wdata = cmd.chr;
    case (state_r)
      tle_pkg::S_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_pop = 1'b1;
          idx_nxt = '0;
          if (!full) begin
            case (cmd.cls)
              tle_pkg::CLS_CR: begin
                // Store the return itself on an empty line
                if (len_r == '0) begin
                  ram_we    = 1'b1;
                  ram_wdata = tle_pkg::CH_CR;
                  len_nxt   = LEN_W'(1);
                end
              end
              tle_pkg::CLS_BS: begin
                if (len_r != '0) begin
                  load     = 1'b1;
                  load_res = '{kind: tle_pkg::KIND_ECHO, data: tle_pkg::CH_BS, last: 1'b0};
                  len_nxt  = len_r - LEN_W'(1);
                end
              end
              tle_pkg::CLS_PRINT: begin
                load     = 1'b1;
                load_res = '{kind: tle_pkg::KIND_ECHO, data: cmd.chr, last: !ends_on_add};
                ram_we   = 1'b1;
                len_nxt  = len_r + LEN_W'(1);
              end
              default: ;
            endcase
          end
        end
      end
      tle_pkg::S_BS_SP: begin
        if (out_free) begin
          load     = 1'b1;
          load_res = '{kind: tle_pkg::KIND_ECHO, data: tle_pkg::CH_SPACE, last: 1'b0};
        end
      end
      tle_pkg::S_BS_END: begin
        if (out_free) begin
          load     = 1'b1;
          load_res = '{kind: tle_pkg::KIND_ECHO, data: tle_pkg::CH_BS, last: 1'b1};
        end
      end
      tle_pkg::S_EMIT: begin
        if (out_free) begin
          load     = 1'b1;
          load_res = '{kind: tle_pkg::KIND_LINE, data: ram_rdata, last: emit_last};
          if (emit_last) begin
            len_nxt = '0;
          end else begin
            idx_nxt = idx_r + AW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tle_pkg::S_IDLE;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= load_res;
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  // Line store, read address takes the next emit index so the registered read data matches the current one
  tle_ram #(
    .WIDTH (tle_pkg::DATA_W),
    .DEPTH (LINE_STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_nxt),
    .rdata (ram_rdata)
  );

endmodule

FILE: sv/terminal_line_editor.sv
// ---------------------------------------------------------------------------
// terminal_line_editor
// Line editor with echo and backspace handling over stream channels.
// ---------------------------------------------------------------------------
// Path: an accepted character is registered in the queue, then the back end
// registers its result in the output register. A backspace walks the BS_SP and
// BS_END states; a line goes through PRIME, then EMIT per byte (store read pipeline).
// A two-entry queue lets the input keep accepting while results are drained.
// Reset clears control, length and registers; the line store is not cleared.
module terminal_line_editor #(
  parameter int LINE_STORE_DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // [7:0] rx_byte
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata,  // [7:0] data_byte
  output logic                          out_tuser,  // [0] item_kind
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tle_pkg::LIMIT_W-1:0]   cfg_wdata
);

  logic                        enable_r;
  logic [tle_pkg::LIMIT_W-1:0] limit_r;
  logic                        q_ready, q_push, q_valid, q_pop;
  tle_pkg::cmd_t               push_cmd, pop_cmd;
  tle_pkg::res_t               res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      limit_r  <= tle_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tle_pkg::REG_ENABLE) begin
        enable_r <= cfg_wdata[0];
      end else if (cfg_index == tle_pkg::REG_LIMIT) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  tle_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .enable    (enable_r),
    .q_ready   (q_ready),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tle_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .ready    (q_ready),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  tle_back #(
    .LINE_STORE_DEPTH (LINE_STORE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (q_valid),
    .cmd        (pop_cmd),
    .cmd_pop    (q_pop),
    .line_limit (limit_r),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = res.data;
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

FILE: sv/tle_checker.sv
// ---------------------------------------------------------------------------
// tle_checker
// Port-level checks for the terminal line editor, bound to the top level.
// ---------------------------------------------------------------------------
module tle_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tvalid,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [7:0]                    out_tdata,
  input logic                          out_tuser,
  input logic                          out_tlast
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Leave reset empty and ready
  a_reset_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_tvalid && in_tready)
    else $error("not idle after reset");

  // Line bytes are printable or a lone return
  a_line_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tle_pkg::KIND_LINE |->
      out_tdata == tle_pkg::CH_CR || out_tdata > tle_pkg::CTRL_TOP)
    else $error("control byte in emitted line");

  // Echo bytes are printable or backspace
  a_echo_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == tle_pkg::KIND_ECHO |->
      out_tdata == tle_pkg::CH_BS || out_tdata > tle_pkg::CTRL_TOP)
    else $error("control byte echoed");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);

FILE: sim/terminal_line_editor_tb.sv
// ---------------------------------------------------------------------------
// terminal_line_editor_tb
// Self-checking bench for the line editor: a directed pass over the character
// classes, the limit and the enable cases, then random typed lines with
// edits and noise under several limits. It runs three idling phases on the
// two stream channels. A predictor tracks the line and queues the echo and
// line bytes awaited on the result channel.
// ---------------------------------------------------------------------------
module terminal_line_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_DEPTH   = 64;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 4000;
  localparam int MAX_PRINTS    = 60;
  localparam int CHUNKS        = 9;
  localparam int CHUNK_ITEMS   = 36;

  // Unused register slots, written to check that they are ignored
  localparam logic [tle_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [tle_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                          clk;
  logic                          rst_n      = 1'b0;
  logic                          in_tvalid  = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata   = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [7:0]                    out_tdata;
  logic                          out_tuser;
  logic                          out_tlast;
  logic                          cfg_we     = 1'b0;
  logic [tle_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [tle_pkg::LIMIT_W-1:0]   cfg_wdata  = '0;

  // Stimulus backlog, awaited results and predictor state
  logic [7:0]     rx_backlog[$];
  tle_pkg::res_t  awaited_q[$];
  logic [7:0]     line_mem[STORE_DEPTH];
  int unsigned    line_len;
  logic           chan_on;
  logic [6:0]     limit_reg;

  int unsigned send_gap_pct   = 30;
  int unsigned recv_stall_pct = 69;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned live_items     = 0;

  terminal_line_editor #(
    .LINE_STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),    // [7:0] rx_byte
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),   // [7:0] data_byte
    .out_tuser (out_tuser),   // [0] item_kind
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bytes a line may hold before it closes by itself
  function automatic int unsigned line_cap(input logic [6:0] lim);
    int unsigned l;
    l = lim;
    if (l < tle_pkg::LIMIT_MIN) l = tle_pkg::LIMIT_MIN;
    if (l > STORE_DEPTH) l = STORE_DEPTH;
    return l - 1;
  endfunction

  task automatic note_mismatch(input string what);
    if (mismatch_count < MAX_PRINTS) $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  // Append the held line as line bytes and clear it
  task automatic dump_line(ref tle_pkg::res_t batch[$]);
    for (int i = 0; i < line_len; i++)
      batch.push_back('{kind: tle_pkg::KIND_LINE, data: line_mem[i], last: 1'b0});
    line_len = 0;
  endtask

  // Predict the results of one accepted character
  task automatic edit_line(input logic [7:0] c);
    tle_pkg::res_t batch[$];
    int unsigned   cap;
    cap = line_cap(limit_reg);
    if (!chan_on) return;
    if (line_len >= cap) begin
      dump_line(batch);
    end else if (c == tle_pkg::CH_CR) begin
      if (line_len == 0) begin
        line_mem[0] = c;
        line_len = 1;
      end
      dump_line(batch);
    end else if (c == tle_pkg::CH_BS) begin
      if (line_len > 0) begin
        batch.push_back('{kind: tle_pkg::KIND_ECHO, data: tle_pkg::CH_BS, last: 1'b0});
        batch.push_back('{kind: tle_pkg::KIND_ECHO, data: tle_pkg::CH_SPACE, last: 1'b0});
        batch.push_back('{kind: tle_pkg::KIND_ECHO, data: tle_pkg::CH_BS, last: 1'b0});
        line_len--;
      end
    end else if (c > tle_pkg::CTRL_TOP) begin
      batch.push_back('{kind: tle_pkg::KIND_ECHO, data: c, last: 1'b0});
      line_mem[line_len] = c;
      line_len++;
      if (line_len >= cap) dump_line(batch);
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) awaited_q.push_back(batch[i]);
  endtask

  // Drive the input channel from the backlog
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (rx_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        in_tdata  <= rx_backlog.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Track register writes and input transactions, check result transactions
  always @(posedge clk) begin
    tle_pkg::res_t want;
    if (!rst_n) begin
      line_len  = 0;
      chan_on   = 1'b0;
      limit_reg = tle_pkg::LIMIT_RESET;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tle_pkg::REG_ENABLE: chan_on = cfg_wdata[0];
          tle_pkg::REG_LIMIT:  limit_reg = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) edit_line(in_tdata);
      if (out_tvalid && out_tready) begin
        if (awaited_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result kind %0b data %02h last %0b",
                                  out_tuser, out_tdata, out_tlast));
        end else begin
          want = awaited_q.pop_front();
          if (out_tuser !== want.kind)
            note_mismatch($sformatf("kind %0b, want %0b", out_tuser, want.kind));
          if (out_tdata !== want.data)
            note_mismatch($sformatf("data %02h, want %02h", out_tdata, want.data));
          if (out_tlast !== want.last)
            note_mismatch($sformatf("last %0b, want %0b", out_tlast, want.last));
        end
      end
    end
  end

  // Watchdog: end the run when no transaction happens for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [tle_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tle_pkg::LIMIT_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Wait until everything sent has been answered, then let the block go quiet
  task automatic settle();
    do @(negedge clk);
    while (rx_backlog.size() != 0 || in_tvalid || awaited_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic feed_text(input string s);
    for (int i = 0; i < s.len(); i++) rx_backlog.push_back(s[i]);
  endtask

  // Queue a typed line with random characters and occasional backspaces
  task automatic type_line(input int unsigned n_chars, input bit end_with_cr);
    for (int i = 0; i < n_chars; i++) begin
      if ($urandom_range(99) < 12) rx_backlog.push_back(tle_pkg::CH_BS);
      else rx_backlog.push_back(8'($urandom_range(32, 255)));
      live_items++;
    end
    if (end_with_cr) begin
      rx_backlog.push_back(tle_pkg::CH_CR);
      live_items++;
    end
  endtask

  initial begin
    logic [7:0]  b;
    logic [6:0]  lim;
    int unsigned quota;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Channel disabled after reset: everything ignored
    feed_text("Q");
    rx_backlog.push_back(tle_pkg::CH_CR);
    settle();

    // Every character class on the default limit
    write_reg(tle_pkg::REG_ENABLE, 7'd1);
    feed_text("A ");
    rx_backlog.push_back(8'hFF);
    rx_backlog.push_back(8'h80);
    rx_backlog.push_back(8'h7F);
    rx_backlog.push_back(tle_pkg::CTRL_TOP);
    rx_backlog.push_back(8'h00);
    rx_backlog.push_back(tle_pkg::CH_BS);
    rx_backlog.push_back(tle_pkg::CH_CR);
    // Return on an empty line, backspace on an empty line
    rx_backlog.push_back(tle_pkg::CH_CR);
    rx_backlog.push_back(tle_pkg::CH_BS);
    settle();

    // Smallest limit, then limits below the range saturating to it
    write_reg(tle_pkg::REG_LIMIT, tle_pkg::LIMIT_MIN);
    feed_text("Z");
    settle();
    write_reg(tle_pkg::REG_LIMIT, 7'd0);
    feed_text("1");
    settle();
    write_reg(tle_pkg::REG_LIMIT, 7'd1);
    feed_text("2");
    settle();

    // Writes to unused indexes change nothing
    write_reg(REG_SPARE_2, 7'h7F);
    write_reg(REG_SPARE_3, 7'h55);

    // Limit above the range, then lowered until the held line is full
    write_reg(tle_pkg::REG_LIMIT, 7'd127);
    feed_text("xy");
    settle();
    write_reg(tle_pkg::REG_LIMIT, 7'd3);
    feed_text("z");
    settle();

    // Disabled channel keeps the held line
    write_reg(tle_pkg::REG_LIMIT, tle_pkg::LIMIT_RESET);
    feed_text("ab");
    settle();
    write_reg(tle_pkg::REG_ENABLE, 7'd0);
    feed_text("c");
    rx_backlog.push_back(tle_pkg::CH_CR);
    settle();
    write_reg(tle_pkg::REG_ENABLE, 7'd1);
    rx_backlog.push_back(tle_pkg::CH_CR);
    settle();

    // Random chunks: typed lines and noise under a fresh limit each
    for (int chunk = 0; chunk < CHUNKS; chunk++) begin
      if (chunk == CHUNKS / 3) begin
        send_gap_pct   = 69;
        recv_stall_pct = 30;
      end else if (chunk == 2 * CHUNKS / 3) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
      if ($urandom_range(9) == 0) begin
        write_reg(tle_pkg::REG_ENABLE, 7'd0);
        repeat (8) rx_backlog.push_back(8'($urandom));
        settle();
      end
      write_reg(tle_pkg::REG_ENABLE, 7'd1);
      case ($urandom_range(9))
        0:       lim = ($urandom_range(1) != 0) ? 7'($urandom_range(0, 1))
                                                : 7'($urandom_range(65, 127));
        1, 2:    lim = 7'($urandom_range(13, 64));
        default: lim = 7'($urandom_range(2, 12));
      endcase
      write_reg(tle_pkg::REG_LIMIT, lim);
      if ($urandom_range(3) == 0)
        write_reg(($urandom_range(1) != 0) ? REG_SPARE_2 : REG_SPARE_3, 7'($urandom));
      quota = live_items + CHUNK_ITEMS;
      while (live_items < quota) begin
        if ($urandom_range(4) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            b = 8'($urandom_range(255));
            rx_backlog.push_back(b);
            if (b > tle_pkg::CTRL_TOP || b == tle_pkg::CH_CR || b == tle_pkg::CH_BS)
              live_items++;
          end
        end else begin
          type_line($urandom_range(0, line_cap(lim) + 2), $urandom_range(99) < 85);
        end
      end
      settle();
    end

    settle();
    if (mismatch_count == 0 && awaited_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/tle_pkg.sv
sv/tle_ram.sv
sv/tle_front.sv
sv/tle_queue.sv
sv/tle_back.sv
sv/terminal_line_editor.sv
sv/tle_checker.sv
sim/terminal_line_editor_tb.sv
